>>> rtl/gpu_page_walker_multi_level_macros.svh
// Assertion macros for the page walker checker.
// Depends on nothing; included by the checker file only.
`ifndef GPU_PAGE_WALKER_MULTI_LEVEL_MACROS_SVH
`define GPU_PAGE_WALKER_MULTI_LEVEL_MACROS_SVH

// same-cycle implication
`define GPWML_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GPWML_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/gpwml_pkg.sv
// Shared types, constants and codes for the page walker.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gpwml_pkg;

   localparam int TABLE_WORDS = 4096;
   localparam int TW_AW       = $clog2(TABLE_WORDS);
   localparam int MAX_DEPTH   = 3;
   localparam logic [1:0] DEPTH_CAP = (MAX_DEPTH > 3) ? 2'd3 : 2'(MAX_DEPTH);

   localparam int PAGE_SHIFT = 12;
   localparam int DIR_BITS   = 9;
   localparam int FRAG_LSB   = 59;
   localparam int FRAG_W     = 5;
   localparam int CSR_AW     = 6;

   localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0] VALID_CLR = ~64'd1;

   typedef enum logic [2:0] {
      REG_VA_START   = 3'd0,
      REG_TABLE_BASE = 3'd1,
      REG_WALK_DEPTH = 3'd2,
      REG_BLOCK_SIZE = 3'd3,
      REG_FB_OFFSET  = 3'd4
   } reg_idx_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_BASE_INV = 2'd1,
      STAT_DIR_INV  = 2'd2,
      STAT_PAGE_INV = 2'd3
   } status_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_XLATE = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      WS_IDLE,
      WS_BASE,
      WS_READ,
      WS_EVAL,
      WS_FINAL
   } walk_state_type;

   typedef struct packed {
      logic [63:0] va_start;
      logic [63:0] table_base;
      logic [1:0]  walk_depth;
      logic [3:0]  block_size;
      logic [63:0] fb_offset;
   } cfg_type;

   typedef struct packed {
      logic [63:0] opa;
      logic [63:0] opb;
      logic        sub;
   } alu_req_type;

endpackage

`default_nettype wire

>>> rtl/gpwml_alu.sv
// Shared 64-bit add/subtract unit of the page walker.
// Depends on gpwml_pkg for the operand struct.
`timescale 1ns / 1ps
`default_nettype none

module gpwml_alu
   import gpwml_pkg::*;
(
   input  alu_req_type alu_req,
   output logic [63:0] alu_res
);

   logic [63:0] opb_eff;

   assign opb_eff = alu_req.sub ? ~alu_req.opb : alu_req.opb;
   assign alu_res = alu_req.opa + opb_eff + {63'd0, alu_req.sub};

endmodule

`default_nettype wire

>>> rtl/gpwml_csr.sv
// Configuration registers of the page walker behind an APB-style port.
// Depends on gpwml_pkg for register indexes and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module gpwml_csr
   import gpwml_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[CSR_AW-1:3]);
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_VA_START:   cfg_in.va_start   = pwdata;
            REG_TABLE_BASE: cfg_in.table_base = pwdata;
            REG_WALK_DEPTH: cfg_in.walk_depth = pwdata[1:0];
            REG_BLOCK_SIZE: cfg_in.block_size = pwdata[3:0];
            REG_FB_OFFSET:  cfg_in.fb_offset  = pwdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_VA_START:   prdata = cfg_ff.va_start;
         REG_TABLE_BASE: prdata = cfg_ff.table_base;
         REG_WALK_DEPTH: prdata = {62'd0, cfg_ff.walk_depth};
         REG_BLOCK_SIZE: prdata = {60'd0, cfg_ff.block_size};
         REG_FB_OFFSET:  prdata = cfg_ff.fb_offset;
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/gpwml_walk.sv
// Walk sequencer, table memory and result register of the page walker.
// Depends on gpwml_pkg and gpwml_alu.
`timescale 1ns / 1ps
`default_nettype none

module gpwml_walk
   import gpwml_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [11:0] req_table_word_addr,
   input  logic [63:0] req_entry_data,
   input  logic [63:0] req_virt_addr,
   input  cfg_type     cfg,
   output logic        rsp_valid,
   output logic [63:0] rsp_xlat_addr,
   output logic        rsp_is_system,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_fail_level
);

   walk_state_type state_ff, state_in;
   logic [63:0]       addr_ff, addr_in;
   logic [63:0]       pba_ff, pba_in;
   logic [FRAG_W-1:0] frag_ff, frag_in;
   logic [1:0]        lvl_ff, lvl_in;
   logic              sys_ff, sys_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_phys_ff, rsp_phys_in;
   logic              rsp_sys_ff, rsp_sys_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [1:0]        rsp_level_ff, rsp_level_in;

   logic [63:0]       mem [TABLE_WORDS];
   logic [63:0]       rd_data_ff;
   logic [TW_AW-1:0]  rd_addr;
   logic [TW_AW-1:0]  wr_addr;
   logic              wr_en;
   logic              xlate_go;

   alu_req_type       alu_req;
   logic [63:0]       alu_res;

   logic [1:0]        depth_eff;
   logic [6:0]        shamt;
   logic              mask_en;
   logic [4:0]        mbits;
   logic [63:0]       idx_full;
   logic [TW_AW-1:0]  idx_mask;
   logic [TW_AW-1:0]  idx;
   logic              use_fb;

   gpwml_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   assign busy      = (state_ff != WS_IDLE);
   assign depth_eff = (cfg.walk_depth > DEPTH_CAP) ? DEPTH_CAP : cfg.walk_depth;
   assign wr_en     = start && !busy && (req_kind_type'(req_type) == REQ_WRITE);
   assign xlate_go  = start && !busy && (req_kind_type'(req_type) == REQ_XLATE);
   assign wr_addr   = TW_AW'({{TW_AW{1'b0}}, req_table_word_addr});
   assign use_fb    = !rd_data_ff[1] && (depth_eff != 2'd0);

   // index of the entry to read at the current level
   always_comb begin
      mask_en = 1'b0;
      mbits   = 5'(DIR_BITS);
      if (depth_eff == 2'd0) begin
         shamt = 7'(PAGE_SHIFT) + 7'(frag_ff);
      end else if (lvl_ff == 2'd0) begin
         shamt   = 7'(PAGE_SHIFT);
         mask_en = 1'b1;
         mbits   = 5'(DIR_BITS) + 5'(cfg.block_size);
      end else begin
         shamt   = 7'(lvl_ff - 2'd1) * 7'(DIR_BITS) + 7'(PAGE_SHIFT + DIR_BITS)
                 + 7'(cfg.block_size);
         mask_en = (lvl_ff != depth_eff);
      end
      idx_full = (shamt < 7'd64) ? (addr_ff >> shamt) : '0;
      for (int i = 0; i < TW_AW; i++) begin
         idx_mask[i] = !mask_en || (i < int'(mbits));
      end
      idx     = idx_full[TW_AW-1:0] & idx_mask;
      rd_addr = pba_ff[TW_AW+2:3] + idx;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         WS_IDLE:  if (xlate_go) state_in = WS_BASE;
         WS_BASE: begin
            if ((depth_eff == 2'd0) && !alu_res[0]) state_in = WS_IDLE;
            else state_in = WS_READ;
         end
         WS_READ:  state_in = WS_EVAL;
         WS_EVAL: begin
            if (!rd_data_ff[0]) state_in = WS_IDLE;
            else if (lvl_ff != 2'd0) state_in = WS_READ;
            else state_in = WS_FINAL;
         end
         WS_FINAL: state_in = WS_IDLE;
         default:  state_in = WS_IDLE;
      endcase
   end

   always_comb begin
      addr_in       = addr_ff;
      pba_in        = pba_ff;
      frag_in       = frag_ff;
      lvl_in        = lvl_ff;
      sys_in        = sys_ff;
      rsp_valid_in  = 1'b0;
      rsp_phys_in   = rsp_phys_ff;
      rsp_sys_in    = rsp_sys_ff;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      alu_req       = '{opa: req_virt_addr, opb: cfg.va_start, sub: 1'b1};
      unique case (state_ff)
         WS_IDLE: begin
            if (xlate_go) addr_in = alu_res;
         end
         WS_BASE: begin
            alu_req = '{opa: cfg.table_base, opb: cfg.fb_offset, sub: 1'b1};
            frag_in = alu_res[FRAG_LSB +: FRAG_W];
            lvl_in  = depth_eff;
            if (depth_eff == 2'd0) begin
               pba_in = alu_res & ADDR_MASK;
               if (!alu_res[0]) begin
                  rsp_valid_in  = 1'b1;
                  rsp_phys_in   = '0;
                  rsp_sys_in    = 1'b0;
                  rsp_status_in = STAT_BASE_INV;
                  rsp_level_in  = 2'd0;
               end
            end else begin
               pba_in = alu_res & VALID_CLR;
            end
         end
         WS_READ: begin
            alu_req = '{opa: addr_ff, opb: '0, sub: 1'b0};
         end
         WS_EVAL: begin
            alu_req = '{opa: rd_data_ff & ADDR_MASK,
                        opb: use_fb ? cfg.fb_offset : 64'd0, sub: 1'b1};
            pba_in  = alu_res;
            if (lvl_ff != 2'd0) begin
               lvl_in = lvl_ff - 2'd1;
               if (!rd_data_ff[0]) begin
                  rsp_valid_in  = 1'b1;
                  rsp_phys_in   = '0;
                  rsp_sys_in    = 1'b0;
                  rsp_status_in = STAT_DIR_INV;
                  rsp_level_in  = depth_eff - lvl_ff + 2'd1;
               end
            end else begin
               sys_in = rd_data_ff[1];
               if (!rd_data_ff[0]) begin
                  rsp_valid_in  = 1'b1;
                  rsp_phys_in   = '0;
                  rsp_sys_in    = 1'b0;
                  rsp_status_in = STAT_PAGE_INV;
                  rsp_level_in  = 2'd0;
               end
            end
         end
         WS_FINAL: begin
            alu_req       = '{opa: pba_ff, opb: {52'd0, addr_ff[PAGE_SHIFT-1:0]}, sub: 1'b0};
            rsp_valid_in  = 1'b1;
            rsp_phys_in   = alu_res;
            rsp_sys_in    = sys_ff;
            rsp_status_in = STAT_OK;
            rsp_level_in  = 2'd0;
         end
         default: begin
            alu_req = '{opa: req_virt_addr, opb: cfg.va_start, sub: 1'b1};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_entry_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      pba_ff        <= pba_in;
      frag_ff       <= frag_in;
      lvl_ff        <= lvl_in;
      sys_ff        <= sys_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_sys_ff    <= rsp_sys_in;
      rsp_status_ff <= rsp_status_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_xlat_addr  = rsp_phys_ff;
   assign rsp_is_system  = rsp_sys_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fail_level = rsp_level_ff;

endmodule

`default_nettype wire

>>> rtl/gpu_page_walker_multi_level.sv
// Top level of the multi-level page walker: configuration port and walk unit.
// Depends on gpwml_pkg, gpwml_csr and gpwml_walk.
//
// Channel   Handshake                   Word
// req_*     start / busy                type, table word address, entry, virtual address
// rsp_*     rsp_valid (one-cycle strobe) physical address, system bit, status, fail level
// csr       psel / penable / pready     64-bit register at byte address 8*index
//
// A table write completes at the accepting edge; busy stays low, no result.
// On a clean walk, busy covers a base step, a read and an evaluate step per level and a
// final step; one shared 64-bit adder and one table memory read port serve the walk.
// The result strobe follows in the next cycle, with busy already low.
// Reset clears the sequencer, strobe and CSRs, not table memory or walk data.
// The receiver cannot stall: every result is taken in its strobe cycle.
`timescale 1ns / 1ps
`default_nettype none

module gpu_page_walker_multi_level
   import gpwml_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [11:0]       req_table_word_addr,
   input  logic [63:0]       req_entry_data,
   input  logic [63:0]       req_virt_addr,
   output logic              rsp_valid,
   output logic [63:0]       rsp_xlat_addr,
   output logic              rsp_is_system,
   output logic [1:0]        rsp_status,
   output logic [1:0]        rsp_fail_level,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   cfg_type cfg;

   gpwml_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gpwml_walk u_walk (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_table_word_addr (req_table_word_addr),
      .req_entry_data      (req_entry_data),
      .req_virt_addr       (req_virt_addr),
      .cfg                 (cfg),
      .rsp_valid           (rsp_valid),
      .rsp_xlat_addr       (rsp_xlat_addr),
      .rsp_is_system       (rsp_is_system),
      .rsp_status          (rsp_status),
      .rsp_fail_level      (rsp_fail_level)
   );

endmodule

`default_nettype wire

>>> rtl/gpwml_checker.sv
// Port-level checks of the page walker, bound to the top level.
// Depends on gpwml_pkg and gpu_page_walker_multi_level_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "gpu_page_walker_multi_level_macros.svh"

module gpwml_checker
   import gpwml_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              req_type,
   input wire logic              rsp_valid,
   input wire logic [63:0]       rsp_xlat_addr,
   input wire logic              rsp_is_system,
   input wire logic [1:0]        rsp_status,
   input wire logic [1:0]        rsp_fail_level
);

   logic wr_take;
   logic xl_take;
   logic fault_word;
   logic nondir_word;
   logic word_clear;

   assign wr_take     = start && !busy && (req_kind_type'(req_type) == REQ_WRITE);
   assign xl_take     = start && !busy && (req_kind_type'(req_type) == REQ_XLATE);
   assign fault_word  = rsp_valid && (status_type'(rsp_status) != STAT_OK);
   assign nondir_word = rsp_valid && (status_type'(rsp_status) != STAT_DIR_INV);
   assign word_clear  = (rsp_xlat_addr == 64'd0) && !rsp_is_system;

   `GPWML_ASSERT_NOW(a_word_idle, clock, reset, rsp_valid, !busy, "result word while busy")
   `GPWML_ASSERT_NEXT(a_write_quiet, clock, reset, wr_take, !busy && !rsp_valid, "write not silent")
   `GPWML_ASSERT_NEXT(a_xlate_busy, clock, reset, xl_take, busy && !rsp_valid, "walk not started")
   `GPWML_ASSERT_NOW(a_fault_zero, clock, reset, fault_word, word_clear, "fault word not cleared")
   `GPWML_ASSERT_NOW(a_level_dir, clock, reset, nondir_word, rsp_fail_level == 2'd0, "stray level")

endmodule

bind gpu_page_walker_multi_level gpwml_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_type       (req_type),
   .rsp_valid      (rsp_valid),
   .rsp_xlat_addr  (rsp_xlat_addr),
   .rsp_is_system  (rsp_is_system),
   .rsp_status     (rsp_status),
   .rsp_fail_level (rsp_fail_level)
);

`default_nettype wire
